// File: rtl/pcs_pkg.sv
// Shared constants for the prime counting sieve.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package pcs_pkg;
  localparam int unsigned N_BITS_DEF      = 24;
  localparam int unsigned TABLE_DEPTH_DEF = 8192;
endpackage

// File: rtl/prime_counting_sieve.sv
// Prime counting block: returns pi(n), the count of primes not above n (zero if the table overflows).
// Uses pcs_pkg and the pcs_div iterative divider.
//
// Channels: in_valid/in_ready carry one limit in_n_value per beat;
// out_valid/out_ready carry one out_prime_count per input beat, in order.
// A new beat is taken only while the block is idle; a finished result sits
// in the output register, so the next beat is taken while it waits.
// Steps: n below 2 answers zero directly. Otherwise a bitwise square root
// of n, then two divisions per distinct quotient of n to fill the table
// (about 2*sqrt(n) entries), then for every prime p up to sqrt(n) up to
// two divisions per quotient at least p*p.
// The shared divider (one quotient bit per cycle) and the single read port
// of each table memory set the run time.
// Reset clears the control state only; table memories are written before
// they are read by every item. A stalled receiver holds the result in the
// output register; a further result waits in the done state until it drains.
`timescale 1ns / 1ps
module prime_counting_sieve import pcs_pkg::*; #(
  parameter int unsigned N_BITS      = N_BITS_DEF,
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [N_BITS-1:0] in_n_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [N_BITS-1:0] out_prime_count
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned IW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HW = (N_BITS + 1) / 2;
  localparam int unsigned PW = 2 * HW;
  localparam int unsigned SW = (HW > 1) ? $clog2(HW) : 1;
  localparam int unsigned XW = ((N_BITS > IW) ? N_BITS : IW) + 2;

  typedef enum logic [4:0] {
    S_IDLE, S_SQRT, S_FDIV1, S_FWAIT1, S_FDIV2, S_FWAIT2,
    S_PCHK, S_PHERE, S_PPREV, S_KCHK, S_KTEST, S_KDIV1, S_KWAIT1,
    S_KDIV2, S_KWAIT2, S_KIDX, S_KUPD, S_LAST, S_DONE
  } state_t;

  state_t            state_r;
  logic [N_BITS-1:0] n_r;
  logic [HW-1:0]     root_r;
  logic [SW-1:0]     sb_r;
  logic [N_BITS:0]   i_r;
  logic [IW-1:0]     used_r;
  logic [HW:0]       p_r;
  logic [PW-1:0]     sq_r;
  logic [IW-1:0]     k_r;
  logic [N_BITS-1:0] here_r;
  logic [N_BITS-1:0] prev_r;
  logic [N_BITS-1:0] ck_r;
  logic [N_BITS-1:0] v_r;
  logic [N_BITS-1:0] vp_r;
  logic [XW-1:0]     idx_r;
  logic              rz_r;
  logic [N_BITS-1:0] res_r;
  logic              out_valid_r;
  logic [N_BITS-1:0] out_cnt_r;

  // table memories
  logic [N_BITS-1:0] q_mem [TABLE_DEPTH];
  logic [N_BITS-1:0] c_mem [TABLE_DEPTH];
  logic [N_BITS-1:0] q_rd_r;
  logic [N_BITS-1:0] c_rd_r;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              q_we;
  logic              c_we;
  logic [N_BITS-1:0] q_wd;
  logic [N_BITS-1:0] c_wd;

  // shared datapath
  logic [HW-1:0]     trial;
  logic [HW-1:0]     mul_a;
  logic [PW-1:0]     mul_p;
  logic              div_start;
  logic [N_BITS-1:0] div_a;
  logic [N_BITS-1:0] div_b;
  logic              div_done;
  logic [N_BITS-1:0] div_q;
  logic [N_BITS:0]   next_i;
  logic              p_go;
  logic [N_BITS-1:0] rc;
  logic              table_full;

  assign trial  = root_r | (HW'(1) << sb_r);
  assign mul_a  = (state_r == S_SQRT) ? trial : p_r[HW-1:0];
  assign mul_p  = PW'(mul_a) * PW'(mul_a);
  assign next_i = (N_BITS + 1)'(div_q) + (N_BITS + 1)'(1);
  assign p_go   = (XW'(p_r) <= XW'(root_r)) && (XW'(p_r) <= XW'(used_r));
  assign rc     = rz_r ? '0 : c_rd_r;
  assign table_full = (used_r == IW'(TABLE_DEPTH));

  pcs_div #(.N_BITS(N_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    div_start = 1'b0;
    div_a     = n_r;
    div_b     = i_r[N_BITS-1:0];
    unique case (state_r)
      S_FDIV1: div_start = 1'b1;
      S_FDIV2: begin
        div_start = 1'b1;
        div_b     = v_r;
      end
      S_KDIV1: begin
        div_start = 1'b1;
        div_a     = v_r;
        div_b     = N_BITS'(p_r);
      end
      S_KDIV2: begin
        div_start = 1'b1;
        div_b     = vp_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      // fetch the count entry for p, or the answer entry once the prime loop is over
      S_PCHK:  rd_addr = p_go ? AW'(IW'(used_r) - IW'(p_r)) : '0;
      S_PHERE: rd_addr = AW'(IW'(used_r) - IW'(p_r) + IW'(1));
      S_KCHK:  rd_addr = k_r[AW-1:0];
      S_KIDX:  rd_addr = idx_r[AW-1:0];
      default: ;
    endcase
  end

  always_comb begin
    q_we    = 1'b0;
    c_we    = 1'b0;
    wr_addr = used_r[AW-1:0];
    q_wd    = div_q;
    c_wd    = div_q - N_BITS'(1);
    priority if (state_r == S_FWAIT1 && div_done && !table_full) begin
      q_we = 1'b1;
      c_we = 1'b1;
    end else if (state_r == S_KUPD) begin
      c_we    = 1'b1;
      wr_addr = k_r[AW-1:0];
      c_wd    = ck_r - (rc - prev_r);
    end else begin
      q_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[wr_addr] <= q_wd;
    end
    q_rd_r <= q_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      c_mem[wr_addr] <= c_wd;
    end
    c_rd_r <= c_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            n_r <= in_n_value;
            if (in_n_value < N_BITS'(2)) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              root_r  <= '0;
              sb_r    <= SW'(HW - 1);
              state_r <= S_SQRT;
            end
          end
        end
        S_SQRT: begin
          if (mul_p <= PW'(n_r)) begin
            root_r <= trial;
          end
          if (sb_r == '0) begin
            i_r     <= (N_BITS + 1)'(1);
            used_r  <= '0;
            state_r <= S_FDIV1;
          end else begin
            sb_r <= sb_r - SW'(1);
          end
        end
        S_FDIV1: state_r <= S_FWAIT1;
        S_FWAIT1: begin
          if (div_done) begin
            v_r <= div_q;
            if (table_full) begin
              // quotients do not fit: answer zero
              res_r   <= '0;
              state_r <= S_DONE;
            end else begin
              used_r  <= used_r + IW'(1);
              state_r <= S_FDIV2;
            end
          end
        end
        S_FDIV2: state_r <= S_FWAIT2;
        S_FWAIT2: begin
          if (div_done) begin
            i_r <= next_i;
            if (next_i <= (N_BITS + 1)'(n_r)) begin
              state_r <= S_FDIV1;
            end else begin
              p_r     <= (HW + 1)'(2);
              state_r <= S_PCHK;
            end
          end
        end
        S_PCHK: state_r <= p_go ? S_PHERE : S_LAST;
        S_PHERE: begin
          here_r  <= c_rd_r;
          state_r <= S_PPREV;
        end
        S_PPREV: begin
          prev_r <= c_rd_r;
          if (here_r <= c_rd_r) begin
            // count did not step up: p is composite
            p_r     <= p_r + (HW + 1)'(1);
            state_r <= S_PCHK;
          end else begin
            sq_r    <= mul_p;
            k_r     <= '0;
            state_r <= S_KCHK;
          end
        end
        S_KCHK: begin
          if (k_r < used_r) begin
            state_r <= S_KTEST;
          end else begin
            p_r     <= p_r + (HW + 1)'(1);
            state_r <= S_PCHK;
          end
        end
        S_KTEST: begin
          v_r  <= q_rd_r;
          ck_r <= c_rd_r;
          if (PW'(q_rd_r) < sq_r) begin
            p_r     <= p_r + (HW + 1)'(1);
            state_r <= S_PCHK;
          end else begin
            state_r <= S_KDIV1;
          end
        end
        S_KDIV1: state_r <= S_KWAIT1;
        S_KWAIT1: begin
          if (div_done) begin
            vp_r <= div_q;
            if (XW'(div_q) <= XW'(root_r)) begin
              idx_r   <= (XW'(div_q) <= XW'(used_r)) ? XW'(used_r) - XW'(div_q)
                                                     : XW'(used_r);
              state_r <= S_KIDX;
            end else begin
              state_r <= S_KDIV2;
            end
          end
        end
        S_KDIV2: state_r <= S_KWAIT2;
        S_KWAIT2: begin
          if (div_done) begin
            idx_r   <= XW'(div_q) - XW'(1);
            state_r <= S_KIDX;
          end
        end
        S_KIDX: begin
          rz_r    <= (idx_r >= XW'(used_r));
          state_r <= S_KUPD;
        end
        S_KUPD: begin
          k_r     <= k_r + IW'(1);
          state_r <= S_KCHK;
        end
        S_LAST: begin
          res_r   <= c_rd_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_cnt_r   <= res_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_prime_count = out_cnt_r;

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while busy");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_FWAIT1 || state_r == S_FWAIT2 ||
                  state_r == S_KWAIT1 || state_r == S_KWAIT2))
    else $error("divider finished outside a wait state");

  a_upd_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KUPD) |-> (k_r < used_r))
    else $error("count update beyond filled table");

  a_sieve_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_KDIV1) |-> (PW'(v_r) >= sq_r))
    else $error("sieving a quotient below p squared");
endmodule

// File: rtl/pcs_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses pcs_pkg for default widths.
`timescale 1ns / 1ps
module pcs_div import pcs_pkg::*; #(
  parameter int unsigned N_BITS = N_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [N_BITS-1:0] dividend,
  input  logic [N_BITS-1:0] divisor,
  output logic              done,
  output logic [N_BITS-1:0] quotient
);
  localparam int unsigned CW = $clog2(N_BITS + 1);

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic [N_BITS:0] rem_r;
  logic [N_BITS-1:0] quo_r;
  logic [N_BITS-1:0] dsr_r;
  logic [N_BITS:0] shifted;
  logic [N_BITS:0] trial;

  assign shifted = {rem_r[N_BITS-1:0], quo_r[N_BITS-1]};
  assign trial   = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(N_BITS);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        // keep the partial remainder when the trial subtraction borrows
        rem_r <= trial[N_BITS] ? shifted : trial;
        quo_r <= {quo_r[N_BITS-2:0], ~trial[N_BITS]};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule
